// File: hdl/half_frequency_mode_finder_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef HALF_FREQUENCY_MODE_FINDER_ASSERT_SVH
`define HALF_FREQUENCY_MODE_FINDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HFMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HFMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hfmf_pkg.sv
package hfmf_pkg;

    localparam int SET_DEPTH = 64;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic        [IDX_W-1:0] t_index;
    typedef logic        [CNT_W-1:0] t_count;

endpackage

// File: hdl/hfmf_ram.sv
module hfmf_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]  o_rd_data_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// File: hdl/half_frequency_mode_finder.sv
// Collects a set of signed 32-bit words, one per accepted input word, until a
// word with i_set_last high arrives, then reports the most frequent value of
// the set (the smallest value wins a tie) if it occurs at least floor(n/2)
// times, and zero otherwise. Up to SET_DEPTH (64) words of a set are kept in a
// memory; words beyond that are dropped, although a dropped word that carries
// i_set_last still ends the set. Loading writes each kept word to the memory.
// After the last word the block compares every stored word against every other
// through the two read ports of the value memory, one pair per cycle, and the
// memory's read is registered. While the comparison runs and while the result
// word waits to be taken, o_stall holds off new input words.
module half_frequency_mode_finder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hfmf_pkg::t_value  i_sample_value,
    input  logic              i_set_last,
    output logic              o_valid,
    input  logic              i_stall,
    output hfmf_pkg::t_value  o_frequent_value
);
    import hfmf_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_WAIT,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    t_count r_count, n_count;
    t_count r_n, n_n;
    t_index r_last_idx, n_last_idx;
    t_index r_i, n_i;
    t_index r_j, n_j;
    logic   r_p_vld, n_p_vld;
    logic   r_p_end, n_p_end;
    logic   r_p_first, n_p_first;
    logic   r_p_final, n_p_final;
    t_count r_tally, n_tally;
    t_count r_best_cnt, n_best_cnt;
    t_value r_best_val, n_best_val;
    t_value r_out_val, n_out_val;
    logic   r_out_vld, n_out_vld;

    logic   accept;
    logic   wr_en;
    t_value rd_a;
    t_value rd_b;
    t_count tally_new;
    t_count n_set;
    logic   take;
    t_count fin_cnt;
    t_value fin_val;

    assign accept = i_valid && (r_state == S_LOAD);
    assign wr_en  = accept && (r_count < t_count'(SET_DEPTH));

    // Port A holds the candidate for a whole pass while port B walks the set.
    hfmf_ram #(
        .DEPTH (SET_DEPTH),
        .WIDTH (VAL_W),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[IDX_W-1:0]),
        .i_wr_data  (i_sample_value),
        .i_rd_addr_a(r_i),
        .o_rd_data_a(rd_a),
        .i_rd_addr_b(r_j),
        .o_rd_data_b(rd_b)
    );

    assign tally_new = r_tally + t_count'(rd_a == rd_b);
    assign n_set     = r_count + t_count'(wr_en);

    // The first candidate always becomes the best; later ones replace it on a
    // higher count, or on an equal count with a smaller signed value.
    assign take = r_p_first || (tally_new > r_best_cnt) ||
                  ((tally_new == r_best_cnt) && (rd_a < r_best_val));
    assign fin_cnt = take ? tally_new : r_best_cnt;
    assign fin_val = take ? rd_a : r_best_val;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_last_idx = r_last_idx;
        n_i        = r_i;
        n_j        = r_j;
        n_p_vld    = 1'b0;
        n_p_end    = r_j == r_last_idx;
        n_p_first  = r_i == '0;
        n_p_final  = (r_i == r_last_idx) && (r_j == r_last_idx);
        n_tally    = r_tally;
        n_best_cnt = r_best_cnt;
        n_best_val = r_best_val;
        n_out_val  = r_out_val;
        n_out_vld  = r_out_vld;

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    n_count = n_set;
                    if (i_set_last) begin
                        n_n        = n_set;
                        n_last_idx = t_index'(n_set - t_count'(1));
                        n_i        = '0;
                        n_j        = '0;
                        n_count    = '0;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_p_vld = 1'b1;
                if (r_j == r_last_idx) begin
                    n_j = '0;
                    n_i = r_i + t_index'(1);
                    if (r_i == r_last_idx) begin
                        n_state = S_WAIT;
                    end
                end else begin
                    n_j = r_j + t_index'(1);
                end
            end
            S_WAIT: begin
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_out_vld = 1'b0;
                    n_state   = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // Compare stage, in the cycle after the address issue.
        if (r_p_vld) begin
            if (r_p_end) begin
                n_tally    = '0;
                n_best_cnt = fin_cnt;
                n_best_val = fin_val;
                if (r_p_final) begin
                    n_out_val = (fin_cnt < (r_n >> 1)) ? '0 : fin_val;
                    n_out_vld = 1'b1;
                    n_state   = S_OUT;
                end
            end else begin
                n_tally = tally_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_last_idx <= n_last_idx;
        r_i        <= n_i;
        r_j        <= n_j;
        r_p_end    <= n_p_end;
        r_p_first  <= n_p_first;
        r_p_final  <= n_p_final;
        r_best_cnt <= n_best_cnt;
        r_best_val <= n_best_val;
        r_out_val  <= n_out_val;
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_p_vld   <= 1'b0;
            r_tally   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_p_vld   <= n_p_vld;
            r_tally   <= n_tally;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall          = r_state != S_LOAD;
    assign o_valid          = r_out_vld;
    assign o_frequent_value = r_out_val;

endmodule

// File: hdl/hfmf_checker.sv
`include "half_frequency_mode_finder_assert.svh"

module hfmf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input hfmf_pkg::t_value i_sample_value,
    input logic             i_set_last,
    input logic             o_valid,
    input logic             i_stall,
    input hfmf_pkg::t_value o_frequent_value
);
    import hfmf_pkg::*;

    `HFMF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_frequent_value), "result word changed while stalled")

    `HFMF_ASSERT_NOW(a_busy_while_out, i_clk, i_rst_n, o_valid, o_stall,
        "input taken while a result word is pending")

    `HFMF_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n,
        i_valid && !o_stall && i_set_last, o_stall && !o_valid,
        "block not busy after the last word of a set")

    `HFMF_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, o_valid && !i_stall, !o_valid,
        "more than one result word for a set")

endmodule

bind half_frequency_mode_finder hfmf_checker u_hfmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_sample_value  (i_sample_value),
    .i_set_last      (i_set_last),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frequent_value(o_frequent_value)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the half-frequency mode finder.
//
// An initial block builds the whole input stream as sets of words. A clocked
// driver offers them in bursts with random gaps. A clocked monitor compares
// every result word with the oldest predicted value. The prediction runs at
// the moment a word is accepted, so the expected queue always mirrors what
// the block has already taken in.
module testbench;

    import hfmf_pkg::*;

    typedef struct {
        t_value value;
        logic   last;
    } t_sample_word;

    // Clock, reset and block ports. Every input has a known value from time zero.
    logic   i_clk            = 1'b0;
    logic   i_rst_n          = 1'b0;
    logic   i_valid          = 1'b0;
    logic   o_stall;
    t_value i_sample_value   = '0;
    logic   i_set_last       = 1'b0;
    logic   o_valid;
    logic   i_stall          = 1'b0;
    t_value o_frequent_value;

    // Words waiting to be offered, the set that the block is currently
    // collecting as the bench sees it, and the results still owed.
    t_sample_word pending_words[$];
    t_value       open_set[$];
    t_value       expected_modes[$];

    int mismatch_count = 0;
    int random_words   = 0;

    // Sender state. A burst runs for burst_left words, then gap_left idle cycles.
    t_sample_word next_word;
    int           burst_left = 0;
    int           gap_left   = 0;

    // Receiver state. stall_mode picks the current stall pattern. hold_left
    // counts down the one long hold-off that makes the input side back up.
    int stall_mode      = 0;
    int mode_left       = 0;
    int pattern_phase   = 0;
    int pattern_on      = 1;
    int pattern_period  = 2;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int results_taken   = 0;

    half_frequency_mode_finder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample_value   (i_sample_value),
        .i_set_last       (i_set_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frequent_value (o_frequent_value)
    );

    always #4 i_clk = ~i_clk;

    // Hold reset once, at the start of the run.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // The run is cut off here if the block stops making progress.
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Most frequent value of a set, the smallest signed value winning a tie.
    // It counts only when it reaches floor(n/2). Otherwise the answer is zero.
    function automatic t_value set_mode(input t_value words[$]);
        t_value best_value;
        int     best_count;
        int     hits;
        best_value = '0;
        best_count = 0;
        foreach (words[i]) begin
            hits = 0;
            foreach (words[j]) begin
                if (words[j] == words[i]) begin
                    hits++;
                end
            end
            if (hits > best_count || (hits == best_count && words[i] < best_value)) begin
                best_count = hits;
                best_value = words[i];
            end
        end
        if (best_count < words.size() / 2) begin
            return '0;
        end
        return best_value;
    endfunction

    // Mirrors the block when a word is accepted. Once the store holds
    // SET_DEPTH words, further words are dropped, but a dropped word
    // that carries set_last still closes the set.
    task automatic take_word(input t_value value, input logic last);
        if (open_set.size() < SET_DEPTH) begin
            open_set = {open_set, value};
        end
        if (last) begin
            expected_modes = {expected_modes, set_mode(open_set)};
            open_set.delete();
        end
    endtask

    task automatic queue_word(input t_value value, input logic last);
        t_sample_word w;
        w.value = value;
        w.last  = last;
        pending_words = {pending_words, w};
    endtask

    task automatic queue_set(input t_value words[$]);
        foreach (words[i]) begin
            queue_word(words[i], i == words.size() - 1);
        end
    endtask

    // A mix of edge values, small numbers near zero and full-range values,
    // so that every bit of the sample field is seen at both levels.
    function automatic t_value pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -1;
            3:       return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // One random set. Most sets are small, because the block compares every
    // pair of words in a set. Some sets are near the store depth, and a few run
    // past it so that the trailing words, the marked one among them, are dropped.
    // The contents come from a small palette with a random bias toward its
    // first entry, which makes majorities, exact halves and ties common.
    task automatic queue_random_set(input bit overflow);
        t_value palette[6];
        t_value value;
        int     set_size;
        int     palette_size;
        int     bias;
        int     shape;
        shape = $urandom_range(0, 99);
        if (overflow || shape < 4) begin
            set_size = $urandom_range(SET_DEPTH + 1, SET_DEPTH + 8);
        end else if (shape < 10) begin
            set_size = $urandom_range(SET_DEPTH / 2, SET_DEPTH);
        end else begin
            set_size = $urandom_range(1, 12);
        end
        palette_size = $urandom_range(1, 6);
        for (int i = 0; i < palette_size; i++) begin
            palette[i] = pick_value();
        end
        bias = $urandom_range(0, 100);
        for (int i = 0; i < set_size; i++) begin
            if ($urandom_range(0, 99) < bias) begin
                value = palette[0];
            end else begin
                value = palette[$urandom_range(0, palette_size - 1)];
            end
            if ($urandom_range(0, 9) == 0) begin
                value = $urandom;
            end
            queue_word(value, i == set_size - 1);
        end
        random_words += set_size;
    endtask

    // The sender. A word is taken at an edge where i_valid is high and o_stall
    // is low. The prediction uses the values still on the ports at that edge.
    // A new word is put up only when the old one is gone or none was offered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                take_word(i_sample_value, i_set_last);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    i_valid        <= 1'b1;
                    i_sample_value <= next_word.value;
                    i_set_last     <= next_word.last;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // About a quarter of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver. The stall pattern is redrawn whenever mode_left runs out.
    // It is either none, a random stall with a one-in-three chance, or a
    // periodic on/off pattern. Once, while a result is on offer, the
    // receiver holds off until hold_left runs out. The result cannot leave,
    // so the block stalls its input while the sender keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && o_valid && results_taken >= 20) begin
                hold_done = 1'b1;
                hold_left = 299;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode     = $urandom_range(0, 2);
                    mode_left      = $urandom_range(50, 300);
                    pattern_period = $urandom_range(2, 9);
                    pattern_on     = $urandom_range(1, pattern_period - 1);
                end else begin
                    mode_left--;
                end
                pattern_phase++;
                case (stall_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 2) == 0);
                    default: i_stall <= (pattern_phase % pattern_period) < pattern_on;
                endcase
            end
        end
    end

    // Every result word that leaves the block is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_modes.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          o_frequent_value));
            end else if (o_frequent_value !== expected_modes[0]) begin
                report_mismatch($sformatf("frequent_value %0d, expected %0d",
                                          o_frequent_value, expected_modes[0]));
                void'(expected_modes.pop_front());
            end else begin
                void'(expected_modes.pop_front());
            end
        end
    end

    // Stimulus, then the end of the run.
    initial begin
        t_value s[$];

        // Single-word sets. floor(1/2) is zero, so the word itself comes back.
        // The most negative, the most positive, zero and minus one.
        s = '{32'sh8000_0000};  queue_set(s);
        s = '{32'sh7fff_ffff};  queue_set(s);
        s = '{0};               queue_set(s);
        s = '{-1};              queue_set(s);
        // A tie between two values. The smaller signed one wins.
        s = '{5, -3, 5, -3};    queue_set(s);
        // Every value is distinct, and one occurrence is below floor(5/2).
        s = '{1, 2, 3, 4, 5};   queue_set(s);
        // Exactly half of an even set.
        s = '{7, 7, 1, 2};      queue_set(s);
        // floor(n/2) on an odd set: two of five is enough.
        s = '{3, 9, 1, 9, 2};   queue_set(s);
        // A tie between the two extremes.
        s = '{32'sh7fff_ffff, 32'sh8000_0000}; queue_set(s);

        // One set runs past the store depth so that the marked word is dropped.
        queue_random_set(1'b1);
        while (random_words < 950) begin
            queue_random_set(1'b0);
        end

        // Every set ends with a marked word, so once the last word is accepted
        // and the last result is in, the block has no work left.
        while (pending_words.size() > 0 || i_valid || expected_modes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: half_frequency_mode_finder.f
+incdir+hdl
hdl/hfmf_pkg.sv
hdl/hfmf_ram.sv
hdl/half_frequency_mode_finder.sv
hdl/hfmf_checker.sv
sim/testbench.sv
